// File: rtl/core/frame_rate_averager_macros.svh
// Assertion macros for the frame rate averager checker.
// Included by bare file name; needs nothing else.
`ifndef FRAME_RATE_AVERAGER_MACROS_SVH
`define FRAME_RATE_AVERAGER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define FRA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fra_checker: same-cycle implication violated");

// Next-cycle implication, switched off while reset is held.
`define FRA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fra_checker: next-cycle implication violated");

`endif

// File: rtl/core/fra_pkg.sv
// Package for the frame rate averager: widths, constants and the divider control type.
// Depends on nothing; used by every module of the block except fra_ram.
`default_nettype none

package fra_pkg;

  localparam int WINDOW = 8;
  localparam int TIME_W = 32;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = TIME_W + $clog2(WINDOW);
  // The divider retires two quotient bits per cycle, so its width is even.
  localparam int DIV_W  = SUM_W + (SUM_W % 2);
  localparam int RATE_W = 24;

  localparam int AVG_STEPS  = DIV_W / 2;
  localparam int RATE_STEPS = RATE_W / 2;
  localparam int STEP_W     = $clog2(AVG_STEPS + 1);

  localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(16000000);
  localparam logic [RATE_W-1:0] RATE_HALF  = RATE_W'(8);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(16000008);
  // The rate dividend sits at the top of the divider word.
  localparam logic [DIV_W-1:0] RATE_DIVIDEND = {RATE_SCALE, {(DIV_W - RATE_W){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/fra_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module fra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/fra_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on fra_pkg for widths and the control struct.
`default_nettype none

module fra_div
  import fra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_ctrl_t         ctrl,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;

  logic [TIME_W:0]   t1, t2, r1, r2;
  logic              ge1, ge2;

  // Two dependent restoring steps: the dividend bits leave the top of quo_r
  // and the quotient bits enter at the bottom.
  always_comb begin
    t1  = {rem_r, quo_r[DIV_W-1]};
    ge1 = (t1 >= {1'b0, dsr_r});
    r1  = ge1 ? (t1 - {1'b0, dsr_r}) : t1;
    t2  = {r1[TIME_W-1:0], quo_r[DIV_W-2]};
    ge2 = (t2 >= {1'b0, dsr_r});
    r2  = ge2 ? (t2 - {1'b0, dsr_r}) : t2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctrl.steps;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = r2[TIME_W-1:0];
      quo_nxt = {quo_r[DIV_W-3:0], ge1, ge2};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/frame_rate_averager.sv
// Frame rate averager: 8-entry moving average of frame intervals and the frame rate.
// The result is registered at the output; an average of zero skips the rate division.
// The block takes a new item only once the last one has reached the output register; the shared
// divider, retiring two bits a cycle, computes first the average and then the rate.
// Reset (synchronous, rst_n low) empties the window, zeroes the previous time and the sum.
`default_nettype none

module frame_rate_averager
  import fra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TIME_W-1:0] in_frame_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TIME_W-1:0] out_avg_interval,
  output logic      [RATE_W-1:0] out_rate_x16
);

  // The block works on one item at a time. A transfer reads the oldest ring
  // entry from the RAM; the next cycle folds it out of the running sum, writes
  // the new interval back and starts the average division. The rate division
  // follows for a nonzero average; the finished pair moves into the output register.
  // Since the write-back happens before the next transfer can be taken, a read
  // and a write of the same entry never overlap and no forwarding is needed.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_AVG,
    S_RATE,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TIME_W-1:0] interval_r, interval_nxt;
  logic [TIME_W-1:0] avg_r, avg_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] out_avg_r, out_avg_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;

  logic              ram_we;
  logic [TIME_W-1:0] ram_rdata;
  logic [TIME_W-1:0] old_interval;

  div_ctrl_t         div_ctrl;
  logic [DIV_W-1:0]  div_dividend;
  logic [TIME_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic              in_xfer;

  assign in_xfer = in_valid && (state_r == S_IDLE);

  // Entries beyond the fill count have never been written since reset and
  // count as zero, so the RAM itself needs no clearing.
  assign old_interval = (CNT_W'(slot_r) < count_r) ? ram_rdata : '0;

  fra_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (interval_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  fra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    interval_nxt  = interval_r;
    avg_nxt       = avg_r;
    rate_nxt      = rate_r;
    out_avg_nxt   = out_avg_r;
    out_rate_nxt  = out_rate_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    div_ctrl      = '0;
    div_dividend  = RATE_DIVIDEND;
    div_divisor   = avg_r;

    case (state_r)
      S_IDLE: begin
        // The interval wraps modulo 2^32 with the timer.
        if (in_valid) begin
          interval_nxt = in_frame_time - prev_r;
          prev_nxt     = in_frame_time;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        sum_nxt   = sum_r - SUM_W'(old_interval) + SUM_W'(interval_r);
        ram_we    = 1'b1;
        slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        count_nxt = (count_r == CNT_W'(WINDOW)) ? count_r : count_r + CNT_W'(1);
        div_ctrl.start = 1'b1;
        div_ctrl.steps = STEP_W'(AVG_STEPS);
        div_dividend   = DIV_W'(sum_nxt);
        div_divisor    = TIME_W'(count_nxt);
        state_nxt      = S_AVG;
      end
      S_AVG: begin
        if (div_done) begin
          avg_nxt = div_quo[TIME_W-1:0];
          if (div_quo[TIME_W-1:0] == '0) begin
            rate_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            div_ctrl.start = 1'b1;
            div_ctrl.steps = STEP_W'(RATE_STEPS);
            div_divisor    = div_quo[TIME_W-1:0];
            state_nxt      = S_RATE;
          end
        end
      end
      S_RATE: begin
        if (div_done) begin
          rate_nxt  = div_quo[RATE_W-1:0] + RATE_HALF;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait here only while an earlier result is still held by the sink.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_rate_nxt  = rate_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    interval_r <= interval_nxt;
    avg_r      <= avg_nxt;
    rate_r     <= rate_nxt;
    out_avg_r  <= out_avg_nxt;
    out_rate_r <= out_rate_nxt;
  end

  assign in_stall         = !in_xfer && (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_avg_interval = out_avg_r;
  assign out_rate_x16     = out_rate_r;

endmodule

`default_nettype wire

// File: rtl/core/fra_checker.sv
// Port-level checker for the frame rate averager, bound to the top level.
// Depends on fra_pkg and frame_rate_averager_macros.svh.
`default_nettype none

`include "frame_rate_averager_macros.svh"

module fra_checker
  import fra_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [TIME_W-1:0] out_avg_interval,
  input wire logic [RATE_W-1:0] out_rate_x16
);

  logic [TIME_W+RATE_W-1:0] payload;
  logic                     avg_zero;
  logic                     rate_zero;

  assign payload   = {out_avg_interval, out_rate_x16};
  assign avg_zero  = (out_avg_interval == '0);
  assign rate_zero = (out_rate_x16 == '0);

  // A held result keeps its payload until it is taken.
  `FRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(payload))

  // One item at a time: a transfer is always followed by a stalled cycle.
  `FRA_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

  // The rate is zero exactly when the average is zero.
  `FRA_ASSERT_IMPL(a_zero_rate, clk, rst_n, out_valid, avg_zero == rate_zero)

  // The rate never exceeds its value at an average of one microsecond.
  `FRA_ASSERT_IMPL(a_rate_max, clk, rst_n, out_valid, out_rate_x16 <= RATE_MAX)

endmodule

bind frame_rate_averager fra_checker u_fra_checker (.*);

`default_nettype wire
